>>> src/c8ie_pkg.sv
// Shared types and constants for the CHIP-8 execute block.
// Holds the request/response payloads, the ALU opcode set and the
// control bundles passed between the sequencer and its units.
package c8ie_pkg;

    localparam int ALU_W = 20;

    localparam logic [1:0] ST_DONE        = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_STACK       = 2'd2;

    typedef enum logic [3:0] {
        ALU_PASS,
        ALU_OR,
        ALU_AND,
        ALU_XOR,
        ALU_ADD8,
        ALU_SUB8,
        ALU_RSUB8,
        ALU_SHR8,
        ALU_SHL8,
        ALU_EQ,
        ALU_ADD,
        ALU_CSUB,
        ALU_MODADD
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_in;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             flag;
    } t_alu_out;

    typedef struct packed {
        logic       we;
        logic [3:0] waddr;
        logic [7:0] wdata;
        logic [3:0] raddr;
    } t_rf_ctl;

    typedef struct packed {
        logic        op;
        logic [15:0] opcode;
        logic [11:0] load_addr;
        logic [7:0]  load_data;
    } t_req;

    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] index;
        logic [7:0]  carry_flag;
        logic [7:0]  delay_value;
        logic [7:0]  sound_value;
        logic [1:0]  status;
    } t_rsp;

endpackage

>>> src/c8ie_alu.sv
// Shared arithmetic, compare and shift unit of the CHIP-8 execute block.
// Depends on c8ie_pkg for the opcode set and operand bundles.
module c8ie_alu #(
    parameter int MEM_DEPTH = 4096
) (
    input  c8ie_pkg::t_alu_in  i_alu,
    output c8ie_pkg::t_alu_out o_alu
);

    localparam logic [c8ie_pkg::ALU_W:0] MOD_V = (c8ie_pkg::ALU_W + 1)'(MEM_DEPTH);

    logic [7:0]                  a8;
    logic [7:0]                  b8;
    logic [8:0]                  s9;
    logic [c8ie_pkg::ALU_W:0]    s;

    always_comb begin
        a8 = i_alu.a[7:0];
        b8 = i_alu.b[7:0];
        s9 = {1'b0, a8} + {1'b0, b8};
        s  = {1'b0, i_alu.a} + {1'b0, i_alu.b};
        o_alu.res  = '0;
        o_alu.flag = 1'b0;
        case (i_alu.op)
            c8ie_pkg::ALU_PASS: begin
                o_alu.res = i_alu.b;
            end
            c8ie_pkg::ALU_OR: begin
                o_alu.res = c8ie_pkg::ALU_W'(a8 | b8);
            end
            c8ie_pkg::ALU_AND: begin
                o_alu.res = c8ie_pkg::ALU_W'(a8 & b8);
            end
            c8ie_pkg::ALU_XOR: begin
                o_alu.res = c8ie_pkg::ALU_W'(a8 ^ b8);
            end
            c8ie_pkg::ALU_ADD8: begin
                o_alu.res  = c8ie_pkg::ALU_W'(s9[7:0]);
                o_alu.flag = s9[8];
            end
            c8ie_pkg::ALU_SUB8: begin
                o_alu.res  = c8ie_pkg::ALU_W'(8'(a8 - b8));
                o_alu.flag = (a8 >= b8);
            end
            c8ie_pkg::ALU_RSUB8: begin
                o_alu.res  = c8ie_pkg::ALU_W'(8'(b8 - a8));
                o_alu.flag = (b8 >= a8);
            end
            c8ie_pkg::ALU_SHR8: begin
                o_alu.res  = c8ie_pkg::ALU_W'({1'b0, a8[7:1]});
                o_alu.flag = a8[0];
            end
            c8ie_pkg::ALU_SHL8: begin
                o_alu.res  = c8ie_pkg::ALU_W'({a8[6:0], 1'b0});
                o_alu.flag = a8[7];
            end
            c8ie_pkg::ALU_EQ: begin
                o_alu.flag = (i_alu.a == i_alu.b);
            end
            c8ie_pkg::ALU_ADD: begin
                o_alu.res = s[c8ie_pkg::ALU_W-1:0];
            end
            c8ie_pkg::ALU_CSUB: begin
                o_alu.flag = (i_alu.a >= i_alu.b);
                o_alu.res  = o_alu.flag ? (i_alu.a - i_alu.b) : i_alu.a;
            end
            c8ie_pkg::ALU_MODADD: begin
                o_alu.flag = (s >= MOD_V);
                o_alu.res  = o_alu.flag ? c8ie_pkg::ALU_W'(s - MOD_V)
                                        : s[c8ie_pkg::ALU_W-1:0];
            end
            default: begin
                o_alu.res  = '0;
                o_alu.flag = 1'b0;
            end
        endcase
    end

endmodule

>>> src/c8ie_regfile.sv
// Sixteen-entry byte register file V0..VF with one write and one
// registered read port; entries read as zero until written after reset.
// Depends on c8ie_pkg for the control bundle.
module c8ie_regfile (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  c8ie_pkg::t_rf_ctl i_ctl,
    output logic [7:0]        o_rdata
);

    logic [7:0]  r_regs [16];
    logic [15:0] r_valid;
    logic [7:0]  r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.we) begin
            r_valid[i_ctl.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_regs[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_rdata <= r_valid[i_ctl.raddr] ? r_regs[i_ctl.raddr] : 8'h00;
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/c8ie_mem.sv
// Single-port byte memory of the CHIP-8 execute block, registered read.
// Stand-alone; contents are undefined until written.
module c8ie_mem #(
    parameter int MEM_DEPTH = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(MEM_DEPTH)-1:0] i_addr,
    input  logic [7:0]                   i_wdata,
    output logic [7:0]                   o_rdata
);

    logic [7:0] r_mem [MEM_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/chip8_instruction_execute.sv
// CHIP-8 execute block: sequencer, call stack and architectural registers.
// Depends on c8ie_pkg, c8ie_alu, c8ie_regfile and c8ie_mem.
// Usage: each request on the input channel (i_in_valid / o_in_stall,
// payload i_in_req) either executes one instruction (op 0) or writes one
// byte into memory (op 1). Every request returns one response on the
// output channel (o_out_valid / i_out_stall, payload o_out_rsp) with PC,
// I, VF, the delay and sound registers and a status code.
// o_in_stall stays high from the accepting edge until the response is
// loaded into the output register, so one request is in work at a time.
// Memory write requests, Fx55 and Fx65 first reduce the base address with
// compare-subtract steps on the shared ALU (S_MOD); Fx55/Fx65 then use
// the ALU and the memory port once per register. The next request is
// taken in S_IDLE, which is entered when the response loads.
// A response held by i_out_stall stays stable; the next request still runs
// and waits in its last step until the output register frees.
// Reset clears V0..VF, I, PC, SP, both timers and both channels; memory
// and call stack keep their contents.
module chip8_instruction_execute #(
    parameter int MEM_DEPTH   = 4096,
    parameter int STACK_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  c8ie_pkg::t_req i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output c8ie_pkg::t_rsp o_out_rsp
);

    localparam int AW   = $clog2(MEM_DEPTH);
    localparam int SI_W = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int KS   = 17 - AW;
    localparam int KS_W = $clog2(KS);
    localparam int W    = c8ie_pkg::ALU_W;

    localparam logic REQ_LOAD = 1'b1;

    localparam logic [3:0] CL_SYS  = 4'h0;
    localparam logic [3:0] CL_JP   = 4'h1;
    localparam logic [3:0] CL_CALL = 4'h2;
    localparam logic [3:0] CL_SE   = 4'h3;
    localparam logic [3:0] CL_SNE  = 4'h4;
    localparam logic [3:0] CL_SER  = 4'h5;
    localparam logic [3:0] CL_LD   = 4'h6;
    localparam logic [3:0] CL_ADD  = 4'h7;
    localparam logic [3:0] CL_ALU  = 4'h8;
    localparam logic [3:0] CL_SNER = 4'h9;
    localparam logic [3:0] CL_LDI  = 4'hA;
    localparam logic [3:0] CL_JPV  = 4'hB;
    localparam logic [3:0] CL_MISC = 4'hF;

    localparam logic [3:0] AL_LD   = 4'h0;
    localparam logic [3:0] AL_OR   = 4'h1;
    localparam logic [3:0] AL_AND  = 4'h2;
    localparam logic [3:0] AL_XOR  = 4'h3;
    localparam logic [3:0] AL_ADD  = 4'h4;
    localparam logic [3:0] AL_SUB  = 4'h5;
    localparam logic [3:0] AL_SHR  = 4'h6;
    localparam logic [3:0] AL_SUBN = 4'h7;
    localparam logic [3:0] AL_SHL  = 4'hE;

    localparam logic [7:0] MI_GDT = 8'h07;
    localparam logic [7:0] MI_SDT = 8'h15;
    localparam logic [7:0] MI_SST = 8'h18;
    localparam logic [7:0] MI_ADI = 8'h1E;
    localparam logic [7:0] MI_STR = 8'h55;
    localparam logic [7:0] MI_LDR = 8'h65;

    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    localparam logic [3:0] REG_V0 = 4'h0;
    localparam logic [3:0] REG_VF = 4'hF;
    localparam logic [3:0] NIB_ZERO = 4'h0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDX,
        S_RDY,
        S_EXEC,
        S_SKIP,
        S_FLAG,
        S_RET,
        S_MOD,
        S_WR,
        S_ST,
        S_LD,
        S_LDL,
        S_VF,
        S_OUT
    } t_state;

    t_state            r_state, n_state;
    c8ie_pkg::t_req    r_req, n_req;
    c8ie_pkg::t_rsp    r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic [11:0]       r_pc, n_pc;
    logic [15:0]       r_idx, n_idx;
    logic [7:0]        r_dt, n_dt;
    logic [7:0]        r_st, n_st;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic [7:0]        r_vx, n_vx;
    logic              r_cond, n_cond;
    logic              r_flag, n_flag;
    logic [W-1:0]      r_acc, n_acc;
    logic [KS_W-1:0]   r_ks, n_ks;
    logic [3:0]        r_cnt, n_cnt;
    logic [3:0]        r_lidx, n_lidx;
    logic              r_lpend, n_lpend;
    logic [1:0]        r_status, n_status;

    logic [11:0]       r_stack [STACK_DEPTH];
    logic [11:0]       r_stk_rd;
    logic              stk_we;
    logic              stk_re;
    logic [SP_W-1:0]   sp_dec;

    c8ie_pkg::t_rf_ctl  rf_ctl;
    logic [7:0]         rf_rdata;
    c8ie_pkg::t_alu_in  alu_in;
    c8ie_pkg::t_alu_out alu_out;
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [7:0]         mem_wdata;
    logic [7:0]         mem_rdata;

    logic [3:0]  w_cls;
    logic [3:0]  w_x;
    logic [3:0]  w_y;
    logic [3:0]  w_n;
    logic [7:0]  w_kk;
    logic [11:0] w_nnn;

    assign w_cls  = r_req.opcode[15:12];
    assign w_x    = r_req.opcode[11:8];
    assign w_y    = r_req.opcode[7:4];
    assign w_n    = r_req.opcode[3:0];
    assign w_kk   = r_req.opcode[7:0];
    assign w_nnn  = r_req.opcode[11:0];
    assign sp_dec = r_sp - 1'b1;

    c8ie_alu #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_alu (
        .i_alu(alu_in),
        .o_alu(alu_out)
    );

    c8ie_regfile u_regfile (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (rf_ctl),
        .o_rdata(rf_rdata)
    );

    c8ie_mem #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[r_sp[SI_W-1:0]] <= r_pc;
        end
        if (stk_re) begin
            r_stk_rd <= r_stack[sp_dec[SI_W-1:0]];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_out       = r_out;
        n_out_valid = r_out_valid & i_out_stall;
        n_pc        = r_pc;
        n_idx       = r_idx;
        n_dt        = r_dt;
        n_st        = r_st;
        n_sp        = r_sp;
        n_vx        = r_vx;
        n_cond      = r_cond;
        n_flag      = r_flag;
        n_acc       = r_acc;
        n_ks        = r_ks;
        n_cnt       = r_cnt;
        n_lidx      = r_lidx;
        n_lpend     = r_lpend;
        n_status    = r_status;

        rf_ctl    = '{we: 1'b0, waddr: w_x, wdata: 8'h00, raddr: w_x};
        alu_in    = '{op: c8ie_pkg::ALU_PASS, a: '0, b: '0};
        mem_we    = 1'b0;
        mem_addr  = r_acc[AW-1:0];
        mem_wdata = r_req.load_data;
        stk_we    = 1'b0;
        stk_re    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_req;
                    n_state = S_RDX;
                end
            end
            S_RDX: begin
                n_status = c8ie_pkg::ST_DONE;
                if (r_req.op == REQ_LOAD) begin
                    n_acc   = W'(r_req.load_addr);
                    n_ks    = KS_W'(KS - 1);
                    n_lpend = 1'b0;
                    n_state = S_MOD;
                end else begin
                    n_state = S_RDY;
                end
            end
            S_RDY: begin
                rf_ctl.raddr = (w_cls == CL_JPV) ? REG_V0 : w_y;
                n_vx         = rf_rdata;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_VF;
                case (w_cls)
                    CL_SYS: begin
                        if (r_req.opcode == OPC_CLS) begin
                            n_status = c8ie_pkg::ST_UNSUPPORTED;
                        end else if (r_req.opcode == OPC_RET) begin
                            if (r_sp == '0) begin
                                n_status = c8ie_pkg::ST_STACK;
                            end else begin
                                n_sp    = sp_dec;
                                stk_re  = 1'b1;
                                n_state = S_RET;
                            end
                        end else begin
                            n_pc = w_nnn;
                        end
                    end
                    CL_JP: begin
                        n_pc = w_nnn;
                    end
                    CL_CALL: begin
                        if (r_sp >= SP_W'(STACK_DEPTH)) begin
                            n_status = c8ie_pkg::ST_STACK;
                        end else begin
                            stk_we = 1'b1;
                            n_sp   = r_sp + 1'b1;
                            n_pc   = w_nnn;
                        end
                    end
                    CL_SE, CL_SNE: begin
                        alu_in  = '{op: c8ie_pkg::ALU_EQ, a: W'(r_vx), b: W'(w_kk)};
                        n_cond  = (w_cls == CL_SE) ? alu_out.flag : !alu_out.flag;
                        n_state = S_SKIP;
                    end
                    CL_SER, CL_SNER: begin
                        if (w_n != NIB_ZERO) begin
                            n_status = c8ie_pkg::ST_UNSUPPORTED;
                        end else begin
                            alu_in  = '{op: c8ie_pkg::ALU_EQ, a: W'(r_vx), b: W'(rf_rdata)};
                            n_cond  = (w_cls == CL_SER) ? alu_out.flag : !alu_out.flag;
                            n_state = S_SKIP;
                        end
                    end
                    CL_LD: begin
                        alu_in       = '{op: c8ie_pkg::ALU_PASS, a: '0, b: W'(w_kk)};
                        rf_ctl.we    = 1'b1;
                        rf_ctl.wdata = alu_out.res[7:0];
                    end
                    CL_ADD: begin
                        alu_in       = '{op: c8ie_pkg::ALU_ADD8, a: W'(r_vx), b: W'(w_kk)};
                        rf_ctl.we    = 1'b1;
                        rf_ctl.wdata = alu_out.res[7:0];
                    end
                    CL_ALU: begin
                        alu_in.a = W'(r_vx);
                        alu_in.b = W'(rf_rdata);
                        case (w_n)
                            AL_LD:   alu_in.op = c8ie_pkg::ALU_PASS;
                            AL_OR:   alu_in.op = c8ie_pkg::ALU_OR;
                            AL_AND:  alu_in.op = c8ie_pkg::ALU_AND;
                            AL_XOR:  alu_in.op = c8ie_pkg::ALU_XOR;
                            AL_ADD:  alu_in.op = c8ie_pkg::ALU_ADD8;
                            AL_SUB:  alu_in.op = c8ie_pkg::ALU_SUB8;
                            AL_SHR:  alu_in.op = c8ie_pkg::ALU_SHR8;
                            AL_SUBN: alu_in.op = c8ie_pkg::ALU_RSUB8;
                            AL_SHL:  alu_in.op = c8ie_pkg::ALU_SHL8;
                            default: alu_in.op = c8ie_pkg::ALU_PASS;
                        endcase
                        case (w_n)
                            AL_LD, AL_OR, AL_AND, AL_XOR: begin
                                rf_ctl.we    = 1'b1;
                                rf_ctl.wdata = alu_out.res[7:0];
                            end
                            AL_ADD, AL_SUB, AL_SHR, AL_SUBN, AL_SHL: begin
                                rf_ctl.we    = 1'b1;
                                rf_ctl.wdata = alu_out.res[7:0];
                                n_flag       = alu_out.flag;
                                n_state      = S_FLAG;
                            end
                            default: begin
                                n_status = c8ie_pkg::ST_UNSUPPORTED;
                            end
                        endcase
                    end
                    CL_LDI: begin
                        n_idx = 16'(w_nnn);
                    end
                    CL_JPV: begin
                        alu_in = '{op: c8ie_pkg::ALU_ADD, a: W'(w_nnn), b: W'(rf_rdata)};
                        n_pc   = alu_out.res[11:0];
                    end
                    CL_MISC: begin
                        case (w_kk)
                            MI_GDT: begin
                                rf_ctl.we    = 1'b1;
                                rf_ctl.wdata = r_dt;
                            end
                            MI_SDT: begin
                                n_dt = r_vx;
                            end
                            MI_SST: begin
                                n_st = r_vx;
                            end
                            MI_ADI: begin
                                alu_in = '{op: c8ie_pkg::ALU_ADD, a: W'(r_idx), b: W'(r_vx)};
                                n_idx  = alu_out.res[15:0];
                            end
                            MI_STR, MI_LDR: begin
                                n_acc   = W'(r_idx);
                                n_ks    = KS_W'(KS - 1);
                                n_lpend = 1'b0;
                                n_state = S_MOD;
                            end
                            default: begin
                                n_status = c8ie_pkg::ST_UNSUPPORTED;
                            end
                        endcase
                    end
                    default: begin
                        n_status = c8ie_pkg::ST_UNSUPPORTED;
                    end
                endcase
            end
            S_SKIP: begin
                alu_in = '{op: c8ie_pkg::ALU_ADD, a: W'(r_pc), b: W'(2)};
                if (r_cond) begin
                    n_pc = alu_out.res[11:0];
                end
                n_state = S_VF;
            end
            S_FLAG: begin
                rf_ctl.we    = 1'b1;
                rf_ctl.waddr = REG_VF;
                rf_ctl.wdata = {7'b0, r_flag};
                n_state      = S_VF;
            end
            S_RET: begin
                n_pc    = r_stk_rd;
                n_state = S_VF;
            end
            S_MOD: begin
                // reduce the base address, preload V0 for the store loop
                rf_ctl.raddr = REG_V0;
                alu_in = '{op: c8ie_pkg::ALU_CSUB, a: r_acc, b: W'(MEM_DEPTH) << r_ks};
                n_acc  = alu_out.res;
                n_cnt  = 4'h0;
                if (r_ks == '0) begin
                    if (r_req.op == REQ_LOAD) begin
                        n_state = S_WR;
                    end else if (w_kk == MI_STR) begin
                        n_state = S_ST;
                    end else begin
                        n_state = S_LD;
                    end
                end else begin
                    n_ks = r_ks - 1'b1;
                end
            end
            S_WR: begin
                mem_we  = 1'b1;
                n_state = S_VF;
            end
            S_ST: begin
                alu_in       = '{op: c8ie_pkg::ALU_MODADD, a: r_acc, b: W'(r_cnt)};
                mem_addr     = alu_out.res[AW-1:0];
                mem_we       = 1'b1;
                mem_wdata    = rf_rdata;
                rf_ctl.raddr = r_cnt + 1'b1;
                if (r_cnt == w_x) begin
                    n_state = S_VF;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_LD: begin
                alu_in   = '{op: c8ie_pkg::ALU_MODADD, a: r_acc, b: W'(r_cnt)};
                mem_addr = alu_out.res[AW-1:0];
                n_lidx   = r_cnt;
                n_lpend  = 1'b1;
                if (r_lpend) begin
                    rf_ctl.we    = 1'b1;
                    rf_ctl.waddr = r_lidx;
                    rf_ctl.wdata = mem_rdata;
                end
                if (r_cnt == w_x) begin
                    n_state = S_LDL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_LDL: begin
                rf_ctl.we    = 1'b1;
                rf_ctl.waddr = r_lidx;
                rf_ctl.wdata = mem_rdata;
                n_state      = S_VF;
            end
            S_VF: begin
                rf_ctl.raddr = REG_VF;
                n_state      = S_OUT;
            end
            S_OUT: begin
                rf_ctl.raddr = REG_VF;
                if (!r_out_valid || !i_out_stall) begin
                    n_out = '{pc: r_pc, index: r_idx, carry_flag: rf_rdata,
                              delay_value: r_dt, sound_value: r_st, status: r_status};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_idx       <= '0;
            r_dt        <= '0;
            r_st        <= '0;
            r_sp        <= '0;
            r_lpend     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pc        <= n_pc;
            r_idx       <= n_idx;
            r_dt        <= n_dt;
            r_st        <= n_st;
            r_sp        <= n_sp;
            r_lpend     <= n_lpend;
        end
        r_req    <= n_req;
        r_out    <= n_out;
        r_vx     <= n_vx;
        r_cond   <= n_cond;
        r_flag   <= n_flag;
        r_acc    <= n_acc;
        r_ks     <= n_ks;
        r_cnt    <= n_cnt;
        r_lidx   <= n_lidx;
        r_status <= n_status;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule
